// File: hw/rtl/zaar_pkg.sv
// ----------------------------------------------------------------------------
// zaar_pkg
// Widths and stage counts shared by the look-at rotation core and its checker.
// ----------------------------------------------------------------------------
package zaar_pkg;

  // input and output field widths
  localparam int IN_W       = 16;
  localparam int OUT_FRAC   = 14;
  localparam int OUT_W      = 16;
  localparam int IN_DATA_W  = 6 * IN_W;
  localparam int OUT_DATA_W = 9 * OUT_W;

  // internal arithmetic widths
  localparam int PR_W  = 2 * IN_W;         // 16x16 product
  localparam int P_W   = 2 * IN_W + 1;     // u x t component, signed
  localparam int PM_W  = 2 * IN_W;         // magnitude of p
  localparam int TP_W  = 3 * IN_W + 1;     // t * p product, signed
  localparam int Q_W   = 3 * IN_W + 2;     // t x p component, signed
  localparam int QM_W  = 3 * IN_W;         // magnitude of q
  localparam int QL_W  = QM_W / 2;         // low half of q for partial products
  localparam int QH_W  = QM_W - QL_W;      // high half
  localparam int SQ_W  = 2 * QM_W;         // squares and sums of squares
  localparam int SRCH_W = SQ_W + 2 * OUT_FRAC + 8;

  // rounding search and pipeline depth
  localparam int NSTEP = OUT_FRAC + 1;     // one result bit per stage
  localparam int LANES = 9;
  localparam int NST   = 9 + NSTEP;        // 8 front stages, search, output

endpackage

// File: hw/rtl/z_axis_align_rotation_core.sv
// ----------------------------------------------------------------------------
// z_axis_align_rotation_core
// Look-at rotation: rows are normalised (up x target), target x perp, target.
// ----------------------------------------------------------------------------
// One beat is accepted per clock while the output is not stalled; each result
// passes through NST stages: eight for the cross products and sums of squares,
// one per result bit for the rounding search, one output register. The
// rounding of every component is an exact restoring search, one bit of the
// Q2.14 result per stage, so the depth follows the number of fraction bits.
// The whole pipeline holds while a result beat waits on m_tready; s_tready
// is low only then. Zero target, zero up and parallel up are replaced as
// usual for a look-at frame.

module z_axis_align_rotation_core
  import zaar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // target_x, target_y, target_z, up_x, up_y, up_z (lowest first)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // perp_row_x/y/z, upfix_row_x/y/z, aim_row_x/y/z (lowest first)
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // pipeline control: global advance
  logic           ce;
  logic [NST:1]   vld;

  assign ce       = m_tready || !vld[NST];
  assign s_tready = ce;
  assign m_tvalid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NST-1:1], s_tvalid};
    end
  end

  // stage 1: unpack, replace zero vectors
  logic signed [IN_W-1:0] ti [3];
  logic signed [IN_W-1:0] ui [3];
  logic signed [IN_W-1:0] t1 [3];
  logic signed [IN_W-1:0] u1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ti[i] = $signed(s_tdata[i*IN_W +: IN_W]);
      ui[i] = $signed(s_tdata[(i+3)*IN_W +: IN_W]);
    end
    if (ti[0] == 0 && ti[1] == 0 && ti[2] == 0) ti[2] = IN_W'(1);
    if (ui[0] == 0 && ui[1] == 0 && ui[2] == 0) ui[1] = IN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t1 <= ti;
      u1 <= ui;
    end
  end

  // stage 2: cross product terms and fallback terms
  logic signed [PR_W-1:0] ut2 [6];
  logic signed [PR_W-1:0] fb2 [5];
  logic signed [IN_W-1:0] t2  [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      ut2[0] <= u1[1] * t1[2];
      ut2[1] <= u1[2] * t1[1];
      ut2[2] <= u1[2] * t1[0];
      ut2[3] <= u1[0] * t1[2];
      ut2[4] <= u1[0] * t1[1];
      ut2[5] <= u1[1] * t1[0];
      fb2[0] <= t1[1] * t1[1];
      fb2[1] <= t1[2] * t1[2];
      fb2[2] <= t1[0] * t1[1];
      fb2[3] <= t1[0] * t1[2];
      fb2[4] <= t1[0] * t1[0];
      t2     <= t1;
    end
  end

  // stage 3: p = u x t, with the parallel-up replacements folded in
  logic signed [P_W-1:0]  pc [3];
  logic signed [P_W-1:0]  pf [3];
  logic signed [P_W-1:0]  p3 [3];
  logic signed [IN_W-1:0] t3 [3];

  always_comb begin
    pc[0] = P_W'(ut2[0]) - P_W'(ut2[1]);
    pc[1] = P_W'(ut2[2]) - P_W'(ut2[3]);
    pc[2] = P_W'(ut2[4]) - P_W'(ut2[5]);
    // up = t x (1,0,0), or t x (0,0,1) when that is zero
    if (t2[1] != 0 || t2[2] != 0) begin
      pf[0] = P_W'(fb2[0]) + P_W'(fb2[1]);
      pf[1] = P_W'(0) - P_W'(fb2[2]);
      pf[2] = P_W'(0) - P_W'(fb2[3]);
    end else begin
      pf[0] = '0;
      pf[1] = '0;
      pf[2] = P_W'(fb2[4]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (pc[0] == 0 && pc[1] == 0 && pc[2] == 0) p3 <= pf;
      else p3 <= pc;
      t3 <= t2;
    end
  end

  // stage 4: squares of p and t, products t * p
  logic [P_W-1:0]          pa [3];
  logic [IN_W-1:0]         ta [3];
  logic [2*PM_W-1:0]       psq4 [3];
  logic [2*IN_W-1:0]       tsq4 [3];
  logic signed [TP_W-1:0]  tp4  [6];
  logic [2:0]              pneg4, tneg4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = p3[i][P_W-1] ? P_W'(-p3[i]) : P_W'(p3[i]);
      ta[i] = t3[i][IN_W-1] ? IN_W'(-t3[i]) : IN_W'(t3[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        psq4[i]  <= pa[i][PM_W-1:0] * pa[i][PM_W-1:0];
        tsq4[i]  <= ta[i] * ta[i];
        pneg4[i] <= p3[i][P_W-1];
        tneg4[i] <= t3[i][IN_W-1];
      end
      tp4[0] <= t3[1] * p3[2];
      tp4[1] <= t3[2] * p3[1];
      tp4[2] <= t3[2] * p3[0];
      tp4[3] <= t3[0] * p3[2];
      tp4[4] <= t3[0] * p3[1];
      tp4[5] <= t3[1] * p3[0];
    end
  end

  // stage 5: q = t x p, sums of squares of p and t
  logic signed [Q_W-1:0]  qc [3];
  logic [Q_W-1:0]         qa [3];
  logic [QM_W-1:0]        qm5  [3];
  logic [2:0]             qneg5, pneg5, tneg5;
  logic [2*PM_W-1:0]      psq5 [3];
  logic [2*IN_W-1:0]      tsq5 [3];
  logic [2*PM_W-1:0]      sp5;
  logic [2*IN_W-1:0]      st5;

  always_comb begin
    qc[0] = Q_W'(tp4[0]) - Q_W'(tp4[1]);
    qc[1] = Q_W'(tp4[2]) - Q_W'(tp4[3]);
    qc[2] = Q_W'(tp4[4]) - Q_W'(tp4[5]);
    for (int i = 0; i < 3; i++) begin
      qa[i] = qc[i][Q_W-1] ? Q_W'(-qc[i]) : Q_W'(qc[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        qm5[i]   <= qa[i][QM_W-1:0];
        qneg5[i] <= qc[i][Q_W-1];
      end
      sp5   <= psq4[0] + psq4[1] + psq4[2];
      st5   <= tsq4[0] + tsq4[1] + tsq4[2];
      psq5  <= psq4;
      tsq5  <= tsq4;
      pneg5 <= pneg4;
      tneg5 <= tneg4;
    end
  end

  // stage 6: partial products of q squared
  logic [2*QH_W-1:0]      qhh6 [3];
  logic [QH_W+QL_W-1:0]   qhl6 [3];
  logic [2*QL_W-1:0]      qll6 [3];
  logic [2:0]             qneg6, pneg6, tneg6;
  logic [2*PM_W-1:0]      psq6 [3];
  logic [2*IN_W-1:0]      tsq6 [3];
  logic [2*PM_W-1:0]      sp6;
  logic [2*IN_W-1:0]      st6;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        qhh6[i] <= qm5[i][QM_W-1:QL_W] * qm5[i][QM_W-1:QL_W];
        qhl6[i] <= qm5[i][QM_W-1:QL_W] * qm5[i][QL_W-1:0];
        qll6[i] <= qm5[i][QL_W-1:0] * qm5[i][QL_W-1:0];
      end
      qneg6 <= qneg5;
      pneg6 <= pneg5;
      tneg6 <= tneg5;
      psq6  <= psq5;
      tsq6  <= tsq5;
      sp6   <= sp5;
      st6   <= st5;
    end
  end

  // stage 7: combine partials into q squared
  logic [SQ_W-1:0]        qsq7 [3];
  logic [2:0]             qneg7, pneg7, tneg7;
  logic [2*PM_W-1:0]      psq7 [3];
  logic [2*IN_W-1:0]      tsq7 [3];
  logic [2*PM_W-1:0]      sp7;
  logic [2*IN_W-1:0]      st7;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        qsq7[i] <= (SQ_W'(qhh6[i]) << (2*QL_W)) + (SQ_W'(qhl6[i]) << (QL_W+1))
                   + SQ_W'(qll6[i]);
      end
      qneg7 <= qneg6;
      pneg7 <= pneg6;
      tneg7 <= tneg6;
      psq7  <= psq6;
      tsq7  <= tsq6;
      sp7   <= sp6;
      st7   <= st6;
    end
  end

  // stage 8: sum of squares of q
  logic [SQ_W-1:0]        qsq8 [3];
  logic [SQ_W-1:0]        sq8;
  logic [2:0]             qneg8, pneg8, tneg8;
  logic [2*PM_W-1:0]      psq8 [3];
  logic [2*IN_W-1:0]      tsq8 [3];
  logic [2*PM_W-1:0]      sp8;
  logic [2*IN_W-1:0]      st8;

  always_ff @(posedge clk) begin
    if (ce) begin
      sq8   <= qsq7[0] + qsq7[1] + qsq7[2];
      qsq8  <= qsq7;
      qneg8 <= qneg7;
      pneg8 <= pneg7;
      tneg8 <= tneg7;
      psq8  <= psq7;
      tsq8  <= tsq7;
      sp8   <= sp7;
      st8   <= st7;
    end
  end

  // lane inputs: component square, row sum of squares, sign
  logic [SQ_W-1:0] lv   [LANES];
  logic [SQ_W-1:0] ls   [LANES];
  logic            lneg [LANES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lv[i]     = SQ_W'(psq8[i]);
      ls[i]     = SQ_W'(sp8);
      lneg[i]   = pneg8[i];
      lv[i+3]   = qsq8[i];
      ls[i+3]   = sq8;
      lneg[i+3] = qneg8[i];
      lv[i+6]   = SQ_W'(tsq8[i]);
      ls[i+6]   = SQ_W'(st8);
      lneg[i+6] = tneg8[i];
    end
  end

  // rounding search: largest n with (2n-1)^2 * S <= 4 * v^2 * 2^(2F),
  // one bit per stage, tracking K^2*S and K*S for K = 2n-1
  logic signed [SRCH_W-1:0] k2s [LANES][NSTEP];
  logic signed [SRCH_W-1:0] kss [LANES][NSTEP];
  logic [SQ_W-1:0]          ssv [LANES][NSTEP];
  logic [SQ_W-1:0]          vsv [LANES][NSTEP];
  logic [NSTEP-1:0]         nnv [LANES][NSTEP];
  logic                     ngv [LANES][NSTEP];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
      localparam int KB = OUT_FRAC - j;
      logic signed [SRCH_W-1:0] k2s_in, ks_in, s_w, a_w, trial;
      logic [SQ_W-1:0]          s_in, v_in;
      logic [NSTEP-1:0]         n_in;
      logic                     neg_in, accept;

      if (j == 0) begin : g_first
        always_comb begin
          s_in   = ls[l];
          v_in   = lv[l];
          neg_in = lneg[l];
          n_in   = '0;
          k2s_in = $signed({{(SRCH_W-SQ_W){1'b0}}, ls[l]});
          ks_in  = SRCH_W'(0) - $signed({{(SRCH_W-SQ_W){1'b0}}, ls[l]});
        end
      end else begin : g_next
        always_comb begin
          s_in   = ssv[l][j-1];
          v_in   = vsv[l][j-1];
          neg_in = ngv[l][j-1];
          n_in   = nnv[l][j-1];
          k2s_in = k2s[l][j-1];
          ks_in  = kss[l][j-1];
        end
      end

      always_comb begin
        s_w    = $signed({{(SRCH_W-SQ_W){1'b0}}, s_in});
        a_w    = $signed({{(SRCH_W-SQ_W){1'b0}}, v_in}) <<< (2*OUT_FRAC+2);
        trial  = k2s_in + (ks_in <<< (KB+2)) + (s_w <<< (2*KB+2));
        accept = (trial <= a_w);
      end

      always_ff @(posedge clk) begin
        if (ce) begin
          k2s[l][j] <= accept ? trial : k2s_in;
          kss[l][j] <= accept ? ks_in + (s_w <<< (KB+1)) : ks_in;
          nnv[l][j] <= n_in | (accept ? (NSTEP'(1) << KB) : NSTEP'(0));
          ssv[l][j] <= s_in;
          vsv[l][j] <= v_in;
          ngv[l][j] <= neg_in;
        end
      end
    end
  end

  // output stage: apply sign
  logic [OUT_W-1:0] res [LANES];
  logic [OUT_W-1:0] mag [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      mag[l] = OUT_W'(nnv[l][NSTEP-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int l = 0; l < LANES; l++) begin
        res[l] <= ngv[l][NSTEP-1] ? OUT_W'(0) - mag[l] : mag[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      m_tdata[l*OUT_W +: OUT_W] = res[l];
    end
  end

endmodule

// File: hw/rtl/zaar_checker.sv
// ----------------------------------------------------------------------------
// zaar_checker
// Port-level checks for the look-at rotation core, bound to the top level.
// ----------------------------------------------------------------------------
module zaar_checker
  import zaar_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int LIM = 2 ** OUT_FRAC;

  // no result beat straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // held result beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // an empty output never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // every component of a unit row is within one
  for (genvar f = 0; f < 9; f++) begin : g_range
    a_range: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (int'($signed(m_tdata[f*OUT_W +: OUT_W])) <= LIM &&
                    int'($signed(m_tdata[f*OUT_W +: OUT_W])) >= -LIM))
      else $error("row component out of range");
  end

  // the aim row is never the zero vector
  a_aim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:6*OUT_W] != '0)
    else $error("aim row is zero");

endmodule

bind z_axis_align_rotation_core zaar_checker u_zaar_checker (.*);

// File: tb/sv/z_axis_align_rotation_core_chk.sv
// ----------------------------------------------------------------------------
// z_axis_align_rotation_core_chk
// Watches both streams of the look-at rotation core, computes the expected
// rotation rows for every accepted input beat and compares the result beats.
// ----------------------------------------------------------------------------
module z_axis_align_rotation_core_chk
  import zaar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output int                    pending
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [OUT_DATA_W-1:0] rows_q[$];
  int                    beat_no;

  // round one component of a non-zero vector to Q2.14, ties away from zero
  function automatic logic [OUT_W-1:0] unit_comp(logic signed [127:0] vi,
                                                 logic [255:0] len2);
    logic [255:0] mag, rhs, lhs, k;
    longint       lo, hi, mid;
    lo  = 0;
    hi  = (64'd1 << OUT_FRAC) + 1;
    mag = (vi < 0) ? 256'(-vi) : 256'(vi);
    rhs = (mag * mag) << (2 * OUT_FRAC + 2);
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      k   = 256'(2 * mid - 1);
      lhs = k * k * len2;
      if (lhs <= rhs) lo = mid;
      else hi = mid;
    end
    return (vi < 0) ? OUT_W'(-lo) : OUT_W'(lo);
  endfunction

  function automatic logic [3*OUT_W-1:0] unit_row(logic signed [127:0] a,
                                                  logic signed [127:0] b,
                                                  logic signed [127:0] c);
    logic [255:0] len2;
    len2 = 256'(a * a) + 256'(b * b) + 256'(c * c);
    if (len2 == 0) return '0;
    return {unit_comp(c, len2), unit_comp(b, len2), unit_comp(a, len2)};
  endfunction

  function automatic logic [OUT_DATA_W-1:0] look_at_rows(logic [IN_DATA_W-1:0] d);
    logic signed [127:0] tx, ty, tz, ux, uy, uz, px, py, pz;
    tx = $signed(d[0*IN_W +: IN_W]);
    ty = $signed(d[1*IN_W +: IN_W]);
    tz = $signed(d[2*IN_W +: IN_W]);
    ux = $signed(d[3*IN_W +: IN_W]);
    uy = $signed(d[4*IN_W +: IN_W]);
    uz = $signed(d[5*IN_W +: IN_W]);
    if (tx == 0 && ty == 0 && tz == 0) tz = 1;
    if (ux == 0 && uy == 0 && uz == 0) uy = 1;
    px = uy * tz - uz * ty;
    py = uz * tx - ux * tz;
    pz = ux * ty - uy * tx;
    // up parallel to target: swap in t x X, else t x Z
    if (px == 0 && py == 0 && pz == 0) begin
      ux = 0; uy = tz; uz = -ty;
      if (uy == 0 && uz == 0) begin
        ux = ty; uy = -tx; uz = 0;
      end
      px = uy * tz - uz * ty;
      py = uz * tx - ux * tz;
      pz = ux * ty - uy * tx;
    end
    return {unit_row(tx, ty, tz),
            unit_row(ty * pz - tz * py, tz * px - tx * pz, tx * py - ty * px),
            unit_row(px, py, pz)};
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR beat %0d: %s", beat_no, what);
    errors++;
  endtask

  assign pending = rows_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (rst) begin
      rows_q.delete();
      beat_no = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rows_q.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = rows_q.pop_front();
          for (int f = 0; f < 9; f++)
            if (m_tdata[f*OUT_W +: OUT_W] !== want[f*OUT_W +: OUT_W])
              report_mismatch($sformatf("field %0d got %h want %h", f,
                                        m_tdata[f*OUT_W +: OUT_W],
                                        want[f*OUT_W +: OUT_W]));
        end
        beat_no++;
      end
      if (s_tvalid && s_tready) rows_q.push_back(look_at_rows(s_tdata));
    end
  end

endmodule

// File: tb/sv/z_axis_align_rotation_core_tb.sv
// ----------------------------------------------------------------------------
// z_axis_align_rotation_core_tb
// Drives directed and random target/up vectors into the look-at rotation core
// with random idling on both sides and one long output stall; the checker
// compares every result beat.
// ----------------------------------------------------------------------------
module z_axis_align_rotation_core_tb
  import zaar_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 1800;
  localparam int MAX_CYCLE = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    errors, pending;
  int                    cycle = 0;
  bit                    calm = 1'b0;
  bit                    stall_done = 1'b0;

  always #1 clk = ~clk;

  z_axis_align_rotation_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  z_axis_align_rotation_core_chk u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  // timeout watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("z_axis_align_rotation_core: mismatch");
      $finish;
    end
  end

  // receiver: random bursts of stall, one long hold-off early on
  initial begin
    int n;
    @(posedge clk iff !rst);
    repeat (40) @(posedge clk);
    m_tready <= 1'b0;
    repeat (300) @(posedge clk);
    stall_done = 1'b1;
    forever begin
      m_tready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
      if (!calm) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [IN_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return IN_W'($urandom_range(0, 6)) - IN_W'(3);
      2: return {1'b1, {(IN_W-1){1'b0}}};
      3: return {1'b0, {(IN_W-1){1'b1}}};
      default: return IN_W'($urandom);
    endcase
  endfunction

  // send one beat, holding tvalid through back-pressure
  task automatic send_vec(logic [IN_W-1:0] tx, ty, tz, ux, uy, uz);
    s_tvalid <= 1'b1;
    s_tdata  <= {uz, uy, ux, tz, ty, tx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    logic [IN_W-1:0] a, b, c, k;
    logic [IN_W-1:0] mx, mn;
    mx = {1'b0, {(IN_W-1){1'b1}}};
    mn = {1'b1, {(IN_W-1){1'b0}}};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero target, zero up, parallel up, both fallbacks, extremes
    send_vec(0, 0, 0, 0, 0, 0);
    send_vec(0, 0, 0, 0, 1, 0);
    send_vec(1, 2, 3, 0, 0, 0);
    send_vec(0, 0, 5, 0, 0, 7);
    send_vec(2, 4, 6, -1, -2, -3);
    send_vec(3, 0, 0, -9, 0, 0);
    send_vec(0, 0, -4, 0, 0, 2);
    send_vec(mx, mx, mx, mn, mn, mn);
    send_vec(mn, mn, mn, mx, mx, mx);
    send_vec(mn, 0, 0, 0, mn, 0);
    send_vec(mx, mn, mx, mn, mx, mn);
    send_vec(mn, mx, 1, 1, mn, mx);
    send_vec(1, 1, 1, -1, 1, -1);
    send_vec(0, 1, 0, 1, 0, 0);
    send_vec(0, mn, 0, 0, mx, 0);
    send_vec(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_vec(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

    // random: mostly general vectors, some parallel or scaled pairs
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i > N_RANDOM - 200) calm = 1'b1;
      idle_gap();
      a = rand_comp(); b = rand_comp(); c = rand_comp();
      if ($urandom_range(0, 7) == 0) begin
        k = IN_W'($urandom_range(0, 4)) - IN_W'(2);
        send_vec(a, b, c, a * k, b * k, c * k);
      end else begin
        send_vec(a, b, c, rand_comp(), rand_comp(), rand_comp());
      end
    end
    s_tvalid <= 1'b0;

    wait (stall_done && pending == 0);
    repeat (3 * NST) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("z_axis_align_rotation_core: match");
    end else begin
      $display("z_axis_align_rotation_core: mismatch");
    end
    $finish;
  end

endmodule
